FILE: rtl/core/fud_pkg.sv
package fud_pkg;

  localparam int TABLE_DEPTH    = 16;
  localparam int DEF_COEF_TERMS = 16;
  localparam int DEF_INDEX_BITS = 12;
  localparam int PIX_BITS       = 12;
  localparam int SQRT_STEPS     = 32;
  localparam int ITER_STEPS     = 31;

  // register indexes of the configuration port
  localparam logic [2:0] REG_CENTER_ROW = 3'd0;
  localparam logic [2:0] REG_CENTER_COL = 3'd1;
  localparam logic [2:0] REG_AFFINE_C   = 3'd2;
  localparam logic [2:0] REG_AFFINE_D   = 3'd3;
  localparam logic [2:0] REG_AFFINE_E   = 3'd4;
  localparam logic [2:0] REG_VIEW_DEPTH = 3'd5;
  localparam logic [2:0] REG_HALF_ROWS  = 3'd6;
  localparam logic [2:0] REG_HALF_COLS  = 3'd7;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic               command;
    logic [3:0]         coef_index;
    logic signed [63:0] coef_value;
    logic [11:0]        out_row;
    logic [11:0]        out_col;
  } req_t;

  typedef struct packed {
    logic signed [31:0] map_row;
    logic signed [31:0] map_col;
  } rsp_t;

  // sign-magnitude product in flight
  typedef struct packed {
    logic         neg;
    logic [63:0]  am;
    logic [63:0]  bm;
    logic [127:0] acc;
  } mul_t;

  // arctangent of 2^-i, Q2.30, rounded to nearest
  function automatic logic signed [31:0] atan_q30(input int i);
    case (i)
      0:  return 32'sd843314857;
      1:  return 32'sd497837829;
      2:  return 32'sd263043837;
      3:  return 32'sd133525159;
      4:  return 32'sd67021687;
      5:  return 32'sd33543516;
      6:  return 32'sd16775851;
      7:  return 32'sd8388437;
      8:  return 32'sd4194283;
      9:  return 32'sd2097149;
      10: return 32'sd1048576;
      11: return 32'sd524288;
      12: return 32'sd262144;
      13: return 32'sd131072;
      14: return 32'sd65536;
      15: return 32'sd32768;
      16: return 32'sd16384;
      17: return 32'sd8192;
      18: return 32'sd4096;
      19: return 32'sd2048;
      20: return 32'sd1024;
      21: return 32'sd512;
      22: return 32'sd256;
      23: return 32'sd128;
      24: return 32'sd64;
      25: return 32'sd32;
      26: return 32'sd16;
      27: return 32'sd8;
      28: return 32'sd4;
      29: return 32'sd2;
      30: return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  function automatic mul_t mul_prep(input logic signed [63:0] a,
                                    input logic signed [63:0] b);
    mul_t m;
    m.neg = a[63] ^ b[63];
    m.am  = mag64(a);
    m.bm  = mag64(b);
    m.acc = '0;
    return m;
  endfunction

  function automatic mul_t mul_lo(input mul_t m);
    logic [63:0] p0;
    logic [63:0] p1;
    mul_t r;
    r  = m;
    p0 = m.am[31:0] * m.bm[31:0];
    p1 = m.am[31:0] * m.bm[63:32];
    r.acc = {64'd0, p0} + {32'd0, p1, 32'd0};
    return r;
  endfunction

  function automatic mul_t mul_hi(input mul_t m);
    logic [63:0] p2;
    logic [63:0] p3;
    mul_t r;
    r  = m;
    p2 = m.am[63:32] * m.bm[31:0];
    p3 = m.am[63:32] * m.bm[63:32];
    r.acc = m.acc + {32'd0, p2, 32'd0} + {p3, 64'd0};
    return r;
  endfunction

  // round half away from zero, shift, saturate
  function automatic logic signed [63:0] mul_fin(input mul_t m, input int s);
    logic [127:0] t;
    t = (m.acc + (128'd1 << (s - 1))) >> s;
    if (m.neg) begin
      if (t > 128'h8000_0000_0000_0000) return S64_MIN;
      return $signed(64'd0 - t[63:0]);
    end
    if (t > 128'h7FFF_FFFF_FFFF_FFFF) return S64_MAX;
    return $signed(t[63:0]);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/core/fisheye_undistort_map_gen.sv
// Fisheye undistortion map generator. Each request word is either a coefficient load
// (command high) or a pixel; a pixel yields one response word with the source row and
// column in Q16.16, a load yields none. One word enters per clock while the pipeline is not
// held, and responses leave in request order. The pipeline is a chain of stages: square
// sum, one square-root bit per stage, 31 CORDIC / ratio-divider steps side by side, five
// stages per Horner step and eight for the scaling and affine products. A stalled
// response holds the whole pipeline, so req_stall follows rsp_valid and rsp_stall.
// Configuration writes are taken at any time but must only be made while the pipeline
// is empty. Coefficients live at the Horner stage that uses them and loads update them
// as they pass, so a load affects exactly the pixels behind it.
module fisheye_undistort_map_gen #(
  parameter int COEF_TERMS = fud_pkg::DEF_COEF_TERMS,
  parameter int INDEX_BITS = fud_pkg::DEF_INDEX_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fud_pkg::req_t req_word,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fud_pkg::rsp_t rsp_word,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  // pixel bits in use
  localparam int PIX_USE = (INDEX_BITS < fud_pkg::PIX_BITS) ? INDEX_BITS : fud_pkg::PIX_BITS;
  localparam logic [11:0] PIX_MASK = 12'((13'd1 << PIX_USE) - 13'd1);

  // stage map
  localparam int ST_SQ    = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_SQRT  = 3;
  localparam int ST_INIT  = ST_SQRT + fud_pkg::SQRT_STEPS;
  localparam int ST_ITER  = ST_INIT + 1;
  localparam int ST_RHO   = ST_ITER + fud_pkg::ITER_STEPS;
  localparam int ST_HORN  = ST_RHO + 1;
  localparam int ST_SCALE = ST_HORN + 5 * (COEF_TERMS - 1);
  localparam int ST_AFF   = ST_SCALE + 4;
  localparam int ST_SUM1  = ST_AFF + 4;
  localparam int ST_OUT   = ST_SUM1 + 1;
  localparam int NSTG     = ST_OUT + 1;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         cidx;
    logic signed [63:0] cval;
    logic [11:0]        row;
    logic [11:0]        col;
    logic               zero;
    logic               xneg;
    logic               yneg;
    logic [31:0]        xm;
    logic [31:0]        ym;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
    logic [63:0]        rem;
    logic [31:0]        root;
    logic signed [39:0] cx;
    logic signed [39:0] cy;
    logic signed [31:0] ang;
    logic [31:0]        rx;
    logic [31:0]        ry;
    logic [30:0]        qx;
    logic [30:0]        qy;
    logic signed [63:0] rho;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic signed [63:0] pr;
    logic signed [63:0] pd;
    logic signed [63:0] pe;
    fud_pkg::mul_t      m0;
    fud_pkg::mul_t      m1;
    fud_pkg::mul_t      m2;
  } pipe_t;

  // one restoring division step: {remainder, quotient/dividend}
  function automatic logic [62:0] div_step(input logic [31:0] rem, input logic [30:0] qd,
                                           input logic [31:0] d);
    logic [32:0] r;
    logic [30:0] q;
    r = {rem, qd[30]};
    q = {qd[29:0], 1'b0};
    if (r >= {1'b0, d}) begin
      r    = r - {1'b0, d};
      q[0] = 1'b1;
    end
    return {r[31:0], q};
  endfunction

  // configuration registers
  logic signed [31:0] center_row;
  logic signed [31:0] center_col;
  logic signed [31:0] affine_c;
  logic signed [31:0] affine_d;
  logic signed [31:0] affine_e;
  logic signed [31:0] view_depth;
  logic [30:0]        half_rows;
  logic [30:0]        half_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_row <= '0;
      center_col <= '0;
      affine_c   <= 32'sd65536;
      affine_d   <= '0;
      affine_e   <= '0;
      view_depth <= -32'sd65536;
      half_rows  <= '0;
      half_cols  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fud_pkg::REG_CENTER_ROW: center_row <= cfg_data;
        fud_pkg::REG_CENTER_COL: center_col <= cfg_data;
        fud_pkg::REG_AFFINE_C:   affine_c   <= cfg_data;
        fud_pkg::REG_AFFINE_D:   affine_d   <= cfg_data;
        fud_pkg::REG_AFFINE_E:   affine_e   <= cfg_data;
        fud_pkg::REG_VIEW_DEPTH: view_depth <= cfg_data;
        fud_pkg::REG_HALF_ROWS:  half_rows  <= cfg_data[30:0];
        fud_pkg::REG_HALF_COLS:  half_cols  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // pipeline
  pipe_t       pipe [NSTG+1];
  pipe_t       nxt  [NSTG];
  logic [NSTG:0] vld;
  logic        adv;

  // coefficient slots, one for the rho start and one per Horner step, index COEF_TERMS-1-n
  logic signed [63:0] coefv [COEF_TERMS];

  assign rsp_valid = vld[NSTG] & ~pipe[NSTG].cmd;
  assign adv       = ~(rsp_valid & rsp_stall);
  assign req_stall = ~adv;

  assign rsp_word.map_row = pipe[NSTG].pr[31:0];
  assign rsp_word.map_col = pipe[NSTG].pe[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-1:0], req_valid};
    end
    if (adv) begin
      pipe[0].cmd  <= req_word.command;
      pipe[0].cidx <= req_word.coef_index;
      pipe[0].cval <= req_word.coef_value;
      pipe[0].row  <= req_word.out_row;
      pipe[0].col  <= req_word.out_col;
      for (int i = 0; i < NSTG; i++) begin
        pipe[i+1] <= nxt[i];
      end
    end
  end

  // coefficient storage: a passing load word rewrites its slot
  for (genvar n = 0; n < COEF_TERMS; n++) begin : g_coef
    localparam int CI = COEF_TERMS - 1 - n;
    localparam int US = (n == 0) ? ST_RHO : ST_HORN + 5 * (n - 1) + 4;
    if (CI < fud_pkg::TABLE_DEPTH) begin : g_slot
      logic signed [63:0] cw;
      always_ff @(posedge clk) begin
        if (rst) begin
          cw <= '0;
        end else if (vld[US] && pipe[US].cmd && pipe[US].cidx == 4'(CI)) begin
          cw <= pipe[US].cval;
        end
      end
      assign coefv[n] = cw;
    end else begin : g_none
      // terms beyond the table are zero
      assign coefv[n] = '0;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    if (i == 0) begin : g_entry
      // ray components, Q16.16
      always_comb begin
        logic signed [33:0] xv;
        logic signed [33:0] yv;
        nxt[i] = pipe[i];
        xv = $signed({6'd0, pipe[i].row & PIX_MASK, 16'd0}) - $signed({3'd0, half_rows});
        yv = $signed({6'd0, pipe[i].col & PIX_MASK, 16'd0}) - $signed({3'd0, half_cols});
        nxt[i].zero = (xv == '0) && (yv == '0);
        nxt[i].xneg = xv[33];
        nxt[i].yneg = yv[33];
        nxt[i].xm   = xv[33] ? 32'(-xv) : xv[31:0];
        nxt[i].ym   = yv[33] ? 32'(-yv) : yv[31:0];
      end
    end else if (i == ST_SQ) begin : g_sq
      always_comb begin
        nxt[i]     = pipe[i];
        nxt[i].sqx = pipe[i].xm * pipe[i].xm;
        nxt[i].sqy = pipe[i].ym * pipe[i].ym;
      end
    end else if (i == ST_SUM) begin : g_sum
      always_comb begin
        nxt[i]      = pipe[i];
        nxt[i].rem  = pipe[i].sqx + pipe[i].sqy;
        nxt[i].root = '0;
      end
    end else if (i < ST_INIT) begin : g_sqrt
      // one root bit per stage, msb first
      localparam int SB = fud_pkg::SQRT_STEPS - 1 - (i - ST_SQRT);
      always_comb begin
        logic [65:0] trial;
        nxt[i] = pipe[i];
        trial  = ({34'd0, pipe[i].root} << (SB + 1)) + (66'd1 << (2 * SB));
        if ({2'd0, pipe[i].rem} >= trial) begin
          nxt[i].rem  = pipe[i].rem - trial[63:0];
          nxt[i].root = pipe[i].root | (32'd1 << SB);
        end
      end
    end else if (i == ST_INIT) begin : g_init
      // cordic on (norm, depth); ratio dividend is mag << 30, top part preloaded
      always_comb begin
        nxt[i]     = pipe[i];
        nxt[i].cx  = $signed({8'd0, pipe[i].root});
        nxt[i].cy  = {{8{view_depth[31]}}, view_depth};
        nxt[i].ang = '0;
        nxt[i].rx  = {1'b0, pipe[i].xm[31:1]};
        nxt[i].ry  = {1'b0, pipe[i].ym[31:1]};
        nxt[i].qx  = {pipe[i].xm[0], 30'd0};
        nxt[i].qy  = {pipe[i].ym[0], 30'd0};
      end
    end else if (i < ST_RHO) begin : g_iter
      localparam int J = i - ST_ITER;
      always_comb begin
        logic signed [39:0] dx;
        logic signed [39:0] dy;
        logic [62:0]        dvx;
        logic [62:0]        dvy;
        nxt[i] = pipe[i];
        dx = pipe[i].cy >>> J;
        dy = pipe[i].cx >>> J;
        if (pipe[i].cy[39]) begin
          nxt[i].cx  = pipe[i].cx - dx;
          nxt[i].cy  = pipe[i].cy + dy;
          nxt[i].ang = pipe[i].ang - fud_pkg::atan_q30(J);
        end else begin
          nxt[i].cx  = pipe[i].cx + dx;
          nxt[i].cy  = pipe[i].cy - dy;
          nxt[i].ang = pipe[i].ang + fud_pkg::atan_q30(J);
        end
        dvx = div_step(pipe[i].rx, pipe[i].qx, pipe[i].root);
        dvy = div_step(pipe[i].ry, pipe[i].qy, pipe[i].root);
        nxt[i].rx = dvx[62:31];
        nxt[i].qx = dvx[30:0];
        nxt[i].ry = dvy[62:31];
        nxt[i].qy = dvy[30:0];
      end
    end else if (i == ST_RHO) begin : g_rho
      always_comb begin
        nxt[i]     = pipe[i];
        nxt[i].rho = coefv[0];
      end
    end else if (i < ST_SCALE) begin : g_horn
      // rho = rho * theta >> 30 + next coefficient, five stages a step
      localparam int HN = (i - ST_HORN) / 5 + 1;
      localparam int HP = (i - ST_HORN) % 5;
      always_comb begin
        nxt[i] = pipe[i];
        if (HP == 0) begin
          nxt[i].m0 = fud_pkg::mul_prep(pipe[i].rho, {{32{pipe[i].ang[31]}}, pipe[i].ang});
        end else if (HP == 1) begin
          nxt[i].m0 = fud_pkg::mul_lo(pipe[i].m0);
        end else if (HP == 2) begin
          nxt[i].m0 = fud_pkg::mul_hi(pipe[i].m0);
        end else if (HP == 3) begin
          nxt[i].rho = fud_pkg::mul_fin(pipe[i].m0, 30);
        end else begin
          nxt[i].rho = fud_pkg::sat_add(pipe[i].rho, coefv[HN]);
        end
      end
    end else if (i < ST_AFF) begin : g_scale
      // unit ratio times rho, >> 46
      localparam int SP = i - ST_SCALE;
      always_comb begin
        logic signed [63:0] ux;
        logic signed [63:0] uy;
        nxt[i] = pipe[i];
        ux = pipe[i].xneg ? -$signed({33'd0, pipe[i].qx}) : $signed({33'd0, pipe[i].qx});
        uy = pipe[i].yneg ? -$signed({33'd0, pipe[i].qy}) : $signed({33'd0, pipe[i].qy});
        if (SP == 0) begin
          nxt[i].m0 = fud_pkg::mul_prep(ux, pipe[i].rho);
          nxt[i].m1 = fud_pkg::mul_prep(uy, pipe[i].rho);
        end else if (SP == 1) begin
          nxt[i].m0 = fud_pkg::mul_lo(pipe[i].m0);
          nxt[i].m1 = fud_pkg::mul_lo(pipe[i].m1);
        end else if (SP == 2) begin
          nxt[i].m0 = fud_pkg::mul_hi(pipe[i].m0);
          nxt[i].m1 = fud_pkg::mul_hi(pipe[i].m1);
        end else begin
          nxt[i].xs = fud_pkg::mul_fin(pipe[i].m0, 46);
          nxt[i].ys = fud_pkg::mul_fin(pipe[i].m1, 46);
        end
      end
    end else if (i < ST_SUM1) begin : g_aff
      // affine products c*xs, d*ys, e*xs
      localparam int AP = i - ST_AFF;
      always_comb begin
        nxt[i] = pipe[i];
        if (AP == 0) begin
          nxt[i].m0 = fud_pkg::mul_prep(pipe[i].xs, {{32{affine_c[31]}}, affine_c});
          nxt[i].m1 = fud_pkg::mul_prep(pipe[i].ys, {{32{affine_d[31]}}, affine_d});
          nxt[i].m2 = fud_pkg::mul_prep(pipe[i].xs, {{32{affine_e[31]}}, affine_e});
        end else if (AP == 1) begin
          nxt[i].m0 = fud_pkg::mul_lo(pipe[i].m0);
          nxt[i].m1 = fud_pkg::mul_lo(pipe[i].m1);
          nxt[i].m2 = fud_pkg::mul_lo(pipe[i].m2);
        end else if (AP == 2) begin
          nxt[i].m0 = fud_pkg::mul_hi(pipe[i].m0);
          nxt[i].m1 = fud_pkg::mul_hi(pipe[i].m1);
          nxt[i].m2 = fud_pkg::mul_hi(pipe[i].m2);
        end else begin
          nxt[i].pr = fud_pkg::mul_fin(pipe[i].m0, 16);
          nxt[i].pd = fud_pkg::mul_fin(pipe[i].m1, 16);
          nxt[i].pe = fud_pkg::mul_fin(pipe[i].m2, 16);
        end
      end
    end else if (i == ST_SUM1) begin : g_sum1
      always_comb begin
        nxt[i]    = pipe[i];
        nxt[i].pr = fud_pkg::sat_add(pipe[i].pr, pipe[i].pd);
        nxt[i].pe = fud_pkg::sat_add(pipe[i].pe, pipe[i].ys);
      end
    end else begin : g_out
      // add centre, clamp to 32 bits; a ray on the axis maps to the centre
      always_comb begin
        logic signed [31:0] r32;
        logic signed [31:0] c32;
        nxt[i] = pipe[i];
        r32 = fud_pkg::sat32(fud_pkg::sat_add(pipe[i].pr, {{32{center_row[31]}}, center_row}));
        c32 = fud_pkg::sat32(fud_pkg::sat_add(pipe[i].pe, {{32{center_col[31]}}, center_col}));
        if (pipe[i].zero) begin
          r32 = center_row;
          c32 = center_col;
        end
        nxt[i].pr = {{32{r32[31]}}, r32};
        nxt[i].pe = {{32{c32[31]}}, c32};
      end
    end
  end

endmodule

FILE: rtl/core/fud_checker.sv
module fud_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input fud_pkg::req_t req_word,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input fud_pkg::rsp_t rsp_word,
  input logic          cfg_write,
  input logic [2:0]    cfg_index,
  input logic [31:0]   cfg_data
);

  // a held response word stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("response word changed while stalled");

  // requests are only held back by a blocked response
  a_req_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a blocked response");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response after reset");

endmodule

bind fisheye_undistort_map_gen fud_checker u_fud_checker (.*);
